[src/laq_pkg.sv]
// ----------------------------------------------------------------------------
// Linear array queue package
// Opcodes, result codes, controller states and the result word type shared
// by the queue controller and the top level.
// ----------------------------------------------------------------------------
package laq_pkg;

   localparam int DATA_W = 32;
   localparam int CAP_W  = 7;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // Byte address of the capacity register
   localparam logic [1:0] CSR_CAP_ADDR = 2'd0;

   typedef enum logic [1:0] {
      OP_ENQ  = 2'd0,
      OP_DEQ  = 2'd1,
      OP_DISP = 2'd2,
      OP_NOP  = 2'd3
   } laq_op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_EMPTY     = 2'd3
   } laq_status_type;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_DEQ,
      CTL_DISP
   } laq_state_type;

   typedef struct packed {
      laq_status_type    status;
      logic [DATA_W-1:0] data;
      logic              last;
   } laq_rsp_type;

endpackage

[src/laq_store.sv]
// ----------------------------------------------------------------------------
// Queue slot store
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Read data holds while no read is issued.
// ----------------------------------------------------------------------------
module laq_store #(
   parameter int DEPTH = 64,
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [IW-1:0]              waddr,
   input  logic [laq_pkg::DATA_W-1:0] wdata,
   input  logic                       rd_en,
   input  logic [IW-1:0]              raddr,
   output logic [laq_pkg::DATA_W-1:0] rd_data
);
   import laq_pkg::*;

   logic [DATA_W-1:0] slot_store_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_store_ff[waddr] <= wdata;
      end
      if (rd_en) begin
         rd_data_ff <= slot_store_ff[raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/laq_ctrl.sv]
// ----------------------------------------------------------------------------
// Queue controller
// Holds head, tail and fill flag, sequences store accesses for each opcode
// and drives the registered result word.
// ----------------------------------------------------------------------------
module laq_ctrl #(
   parameter int DEPTH = 64,
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  laq_pkg::laq_op_type        req_op,
   input  logic [laq_pkg::DATA_W-1:0] req_data,
   input  logic [laq_pkg::CAP_W-1:0]  cap_eff,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output laq_pkg::laq_rsp_type       rsp,
   output logic                       mem_wr_en,
   output logic [IW-1:0]              mem_waddr,
   output logic [laq_pkg::DATA_W-1:0] mem_wdata,
   output logic                       mem_rd_en,
   output logic [IW-1:0]              mem_raddr,
   input  logic [laq_pkg::DATA_W-1:0] mem_rd_data
);
   import laq_pkg::*;

   laq_state_type state_ff, state_in;
   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] tail_ff, tail_in;
   logic          occ_ff, occ_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   laq_rsp_type   rsp_ff, rsp_in;

   logic out_free;
   logic accept;
   logic full;
   logic disp_last;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == CTL_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign full      = (cap_eff == '0)
                   || (occ_ff && (CAP_W'(tail_ff) >= (cap_eff - CAP_W'(1))));
   assign disp_last = (idx_ff == tail_ff);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      occ_in       = occ_ff;
      idx_in       = idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_wr_en    = 1'b0;
      mem_waddr    = tail_ff;
      mem_wdata    = req_data;
      mem_rd_en    = 1'b0;
      mem_raddr    = head_ff;

      unique case (state_ff)
         CTL_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_ENQ: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        rsp_in = '{status: ST_OVERFLOW, data: '0, last: 1'b1};
                     end else begin
                        // an empty queue restarts at slot zero
                        if (!occ_ff) begin
                           head_in   = '0;
                           tail_in   = '0;
                           occ_in    = 1'b1;
                           mem_waddr = '0;
                        end else begin
                           tail_in   = tail_ff + IW'(1);
                           mem_waddr = tail_ff + IW'(1);
                        end
                        mem_wr_en = 1'b1;
                        rsp_in = '{status: ST_OK, data: '0, last: 1'b1};
                     end
                  end
                  OP_DEQ: begin
                     if (!occ_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{status: ST_UNDERFLOW, data: '0, last: 1'b1};
                     end else begin
                        mem_rd_en = 1'b1;
                        if (head_ff >= tail_ff) begin
                           head_in = '0;
                           tail_in = '0;
                           occ_in  = 1'b0;
                        end else begin
                           head_in = head_ff + IW'(1);
                        end
                        state_in = CTL_DEQ;
                     end
                  end
                  OP_DISP: begin
                     if (!occ_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{status: ST_EMPTY, data: '0, last: 1'b1};
                     end else begin
                        mem_rd_en = 1'b1;
                        idx_in    = head_ff;
                        state_in  = CTL_DISP;
                     end
                  end
                  OP_NOP: begin
                  end
               endcase
            end
         end
         CTL_DEQ: begin
            rsp_valid_in = 1'b1;
            rsp_in = '{status: ST_OK, data: mem_rd_data, last: 1'b1};
            state_in = CTL_IDLE;
         end
         CTL_DISP: begin
            // read data holds until the result word is free
            mem_raddr = idx_ff + IW'(1);
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{status: ST_OK, data: mem_rd_data, last: disp_last};
               if (disp_last) begin
                  state_in = CTL_IDLE;
               end else begin
                  mem_rd_en = 1'b1;
                  idx_in    = idx_ff + IW'(1);
               end
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTL_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_empty_idx_zero: assert property (@(posedge clock) disable iff (reset)
      !occ_ff |-> (head_ff == '0) && (tail_ff == '0))
      else $error("empty queue with non-zero index");

   a_head_le_tail: assert property (@(posedge clock) disable iff (reset)
      occ_ff |-> (head_ff <= tail_ff))
      else $error("head beyond tail");

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff != CTL_IDLE) |-> !req_ready)
      else $error("word accepted while busy");

   a_deq_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CTL_DEQ) |-> !rsp_valid_ff)
      else $error("dequeue result would overwrite pending word");

   a_disp_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CTL_DISP) |-> occ_ff && (idx_ff <= tail_ff) && (idx_ff >= head_ff))
      else $error("display index outside stored range");

endmodule

[src/linear_array_queue.sv]
// ----------------------------------------------------------------------------
// Linear array queue
// Non-circular queue of 32-bit words with enqueue, dequeue and display.
// ----------------------------------------------------------------------------
// The queue keeps its words in a synchronous RAM of DEPTH slots and works on
// one request word at a time. Enqueue writes at the tail and returns its
// status in the cycle after acceptance. Dequeue reads the head slot into the
// read register of the slot RAM and then loads the result word from it.
// Display of N stored words returns N result words, the first after the RAM
// read and then one a cycle while the result side keeps up. A new request is
// taken at the earliest at the edge where the final word of the previous one
// leaves the output register. Freed slots at the front are not reused until
// the queue has fully drained, at which point head and tail return to zero.
// The capacity register (byte address 0) is clamped to DEPTH where it is
// used; a capacity of zero makes every enqueue overflow.
// ----------------------------------------------------------------------------
module linear_array_queue #(
   parameter int DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,

   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] data_in
   input  logic [1:0]  req_tuser,   // [1:0] opcode

   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] data_out
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast,

   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import laq_pkg::*;

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [CAP_W-1:0] DEPTH_CAP = CAP_W'(DEPTH);

   logic [CAP_W-1:0]  cap_ff;
   logic [CAP_W-1:0]  cap_eff;
   logic              csr_wr;

   laq_rsp_type       rsp;
   logic              mem_wr_en;
   logic [IW-1:0]     mem_waddr;
   logic [DATA_W-1:0] mem_wdata;
   logic              mem_rd_en;
   logic [IW-1:0]     mem_raddr;
   logic [DATA_W-1:0] mem_rd_data;

   // Register port: ready always asserted, capacity held in 7 bits
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_wr && (csr_paddr == CSR_CAP_ADDR)) begin
         cap_ff <= csr_pwdata[CAP_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr == CSR_CAP_ADDR) ? {{(32-CAP_W){1'b0}}, cap_ff} : '0;

   // Clamp the capacity to the slots actually built
   assign cap_eff = (cap_ff > DEPTH_CAP) ? DEPTH_CAP : cap_ff;

   laq_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_op      (laq_op_type'(req_tuser)),
      .req_data    (req_tdata),
      .cap_eff     (cap_eff),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp         (rsp),
      .mem_wr_en   (mem_wr_en),
      .mem_waddr   (mem_waddr),
      .mem_wdata   (mem_wdata),
      .mem_rd_en   (mem_rd_en),
      .mem_raddr   (mem_raddr),
      .mem_rd_data (mem_rd_data)
   );

   laq_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .waddr   (mem_waddr),
      .wdata   (mem_wdata),
      .rd_en   (mem_rd_en),
      .raddr   (mem_raddr),
      .rd_data (mem_rd_data)
   );

   // Unpack the result word onto the stream
   assign rsp_tdata = rsp.data;
   assign rsp_tuser = rsp.status;
   assign rsp_tlast = rsp.last;

endmodule
